>>> src/bsp_pkg.sv
// Shared types and constants of the beep sequence player.
// No dependencies; every other source file imports this package.
package bsp_pkg;

	localparam int QUEUE_SLOTS = 5;
	localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
	localparam int LEN_W       = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CQ_DEPTH    = 2;
	localparam int CQ_AW       = $clog2(CQ_DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL_PAUSE = 2'd1;

	localparam logic [CFG_W-1:0] GAP_TICKS_RESET   = 16'd100;
	localparam logic [CFG_W-1:0] FINAL_PAUSE_RESET = 16'd1000;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_ENQUEUE = 1'b1;

	localparam logic [1:0] PHASE_IDLE  = 2'd0;
	localparam logic [1:0] PHASE_SOUND = 2'd1;
	localparam logic [1:0] PHASE_GAP   = 2'd2;
	localparam logic [1:0] PHASE_PAUSE = 2'd3;

	typedef struct packed {
		logic             cmd;
		logic [LEN_W-1:0] beep_length;
		logic             beep_final;
	} in_item_t;

	typedef struct packed {
		logic       buzzer_on;
		logic       busy_res;
		logic       dropped;
		logic [1:0] phase;
	} out_item_t;

	typedef enum logic {
		KIND_TICK,
		KIND_ENQUEUE
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [LEN_W-1:0] len;
		logic             fin;
	} cq_entry_t;

	typedef struct packed {
		logic      valid;
		cq_entry_t entry;
	} cq_head_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             fin;
	} beep_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_SOUND = 4'b0010,
		PH_GAP   = 4'b0100,
		PH_PAUSE = 4'b1000
	} phase_t;

endpackage

>>> src/bsp_if.sv
// Valid/ready channel interfaces for requests in and results out.
// Depends on bsp_pkg for the payload types.
interface bsp_in_if;
	import bsp_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bsp_out_if;
	import bsp_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/beep_sequence_player_core.sv
// Beep sequence player: one result per request, accepted and delivered at up to one per cycle.
// Path: an accepted request is written into the front queue; the back end takes it from the
// head and registers its result; queue write and player update are each one register stage.
// Throughput: one request per cycle while the result register is free or draining.
// Reset (arst_n low): queue, ring pointers, phase, counters and result valid clear at once,
// gap_ticks returns to 100 and final_pause_ticks to 1000; the beep store keeps its contents.
module beep_sequence_player_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bsp_in_if.sink                        items,
	bsp_out_if.source                     results,
	input  logic                          write_en,
	input  logic [bsp_pkg::CFG_IDX_W-1:0] reg_index,
	input  logic [bsp_pkg::CFG_W-1:0]     write_data
);
	import bsp_pkg::*;

	// Classified request at the head of the front queue.
	cq_head_t head;
	// Back end takes the head request this cycle.
	logic     pop;

	// Front: accept requests and park them so the back end can stall on its own.
	bsp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.head   (head),
		.pop    (pop)
	);

	// Back: run the ring and the phase sequencer, hold each result until it is taken.
	bsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.results    (results),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data)
	);

endmodule

>>> src/bsp_front.sv
// Front end: accept requests, classify them and hold them in a short queue.
// Depends on bsp_pkg and bsp_if.
module bsp_front (
	input  logic              clk,
	input  logic              arst_n,
	bsp_in_if.sink            items,
	output bsp_pkg::cq_head_t head,
	input  logic              pop
);
	import bsp_pkg::*;

	cq_entry_t        cq_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   count_q;
	logic             push;
	logic             do_pop;
	cq_entry_t        incoming;

	function automatic logic [CQ_AW-1:0] bump(input logic [CQ_AW-1:0] p);
		return (p == CQ_AW'(CQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign items.ready = (count_q != (CQ_AW+1)'(CQ_DEPTH));
	assign push        = items.valid && items.ready;
	assign do_pop      = pop && head.valid;

	always_comb begin
		incoming.kind = (items.data.cmd == CMD_ENQUEUE) ? KIND_ENQUEUE : KIND_TICK;
		incoming.len  = items.data.beep_length;
		incoming.fin  = items.data.beep_final;
	end

	assign head.valid = (count_q != '0);
	assign head.entry = cq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cq_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			count_q <= count_q + (CQ_AW+1)'(push) - (CQ_AW+1)'(do_pop);
		end
	end

endmodule

>>> src/bsp_back.sv
// Back end: beep ring, phase sequencer, tick counter and the result register.
// Depends on bsp_pkg and bsp_if.
module bsp_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bsp_pkg::cq_head_t               head,
	output logic                            pop,
	bsp_out_if.source                       results,
	input  logic                            write_en,
	input  logic [bsp_pkg::CFG_IDX_W-1:0]   reg_index,
	input  logic [bsp_pkg::CFG_W-1:0]       write_data
);
	import bsp_pkg::*;

	beep_t             store_q [QUEUE_SLOTS];
	logic [SLOT_W-1:0] read_slot_q, read_slot_nx;
	logic [SLOT_W-1:0] write_slot_q, write_slot_nx;
	phase_t            phase_q, phase_nx;
	logic [LEN_W-1:0]  elapsed_q, elapsed_nx, elapsed_inc;
	logic [LEN_W-1:0]  cur_len_q, cur_len_nx;
	logic              cur_fin_q, cur_fin_nx;
	logic              busy_q, busy_nx;
	logic [CFG_W-1:0]  gap_ticks_q;
	logic [CFG_W-1:0]  final_pause_q;
	logic              res_valid_q;
	out_item_t         res_q;
	logic              step;
	logic              ring_full;
	logic              store_we;
	logic              drop;
	beep_t             head_beep;
	logic [1:0]        phase_code;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	// One request per cycle whenever the result register is free or draining.
	assign step      = head.valid && (!res_valid_q || results.ready);
	assign pop       = step;
	assign ring_full = (next_slot(write_slot_q) == read_slot_q);
	assign head_beep = store_q[read_slot_q];
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		read_slot_nx  = read_slot_q;
		write_slot_nx = write_slot_q;
		phase_nx      = phase_q;
		elapsed_nx    = elapsed_q;
		cur_len_nx    = cur_len_q;
		cur_fin_nx    = cur_fin_q;
		busy_nx       = busy_q;
		store_we      = 1'b0;
		drop          = 1'b0;
		if (step) begin
			if (head.entry.kind == KIND_ENQUEUE) begin
				if (ring_full) begin
					drop = 1'b1;
				end else begin
					store_we      = 1'b1;
					write_slot_nx = next_slot(write_slot_q);
				end
			end else begin
				elapsed_nx = elapsed_inc;
				unique case (phase_q)
					PH_IDLE: begin
						if (read_slot_q != write_slot_q) begin
							cur_len_nx   = head_beep.len;
							cur_fin_nx   = head_beep.fin;
							read_slot_nx = next_slot(read_slot_q);
							elapsed_nx   = '0;
							phase_nx     = PH_SOUND;
							busy_nx      = 1'b1;
						end
					end
					PH_SOUND: begin
						if (elapsed_inc >= cur_len_q) begin
							elapsed_nx = '0;
							phase_nx   = PH_GAP;
						end
					end
					PH_GAP: begin
						if (elapsed_inc >= gap_ticks_q) begin
							elapsed_nx = '0;
							phase_nx   = cur_fin_q ? PH_PAUSE : PH_IDLE;
						end
					end
					PH_PAUSE: begin
						// End of alert: flush whatever is still queued.
						if (elapsed_inc >= final_pause_q) begin
							elapsed_nx    = '0;
							read_slot_nx  = '0;
							write_slot_nx = '0;
							phase_nx      = PH_IDLE;
							busy_nx       = 1'b0;
						end
					end
					default: begin
						phase_nx = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (phase_nx)
			PH_IDLE:  phase_code = PHASE_IDLE;
			PH_SOUND: phase_code = PHASE_SOUND;
			PH_GAP:   phase_code = PHASE_GAP;
			PH_PAUSE: phase_code = PHASE_PAUSE;
			default:  phase_code = PHASE_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[write_slot_q] <= '{len: head.entry.len, fin: head.entry.fin};
		end
		if (step) begin
			res_q.buzzer_on <= (phase_nx == PH_SOUND);
			res_q.busy_res  <= busy_nx;
			res_q.dropped   <= drop;
			res_q.phase     <= phase_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_slot_q   <= '0;
			write_slot_q  <= '0;
			phase_q       <= PH_IDLE;
			elapsed_q     <= '0;
			cur_len_q     <= '0;
			cur_fin_q     <= 1'b0;
			busy_q        <= 1'b0;
			gap_ticks_q   <= GAP_TICKS_RESET;
			final_pause_q <= FINAL_PAUSE_RESET;
			res_valid_q   <= 1'b0;
		end else begin
			read_slot_q  <= read_slot_nx;
			write_slot_q <= write_slot_nx;
			phase_q      <= phase_nx;
			elapsed_q    <= elapsed_nx;
			cur_len_q    <= cur_len_nx;
			cur_fin_q    <= cur_fin_nx;
			busy_q       <= busy_nx;
			if (write_en) begin
				unique case (reg_index)
					CFG_GAP_TICKS:   gap_ticks_q   <= write_data;
					CFG_FINAL_PAUSE: final_pause_q <= write_data;
					default: ;
				endcase
			end
			if (step) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

endmodule

>>> src/bsp_checker.sv
// Port-level checks on the beep sequence player results.
// Depends on bsp_pkg; bound to beep_sequence_player_core below.
module bsp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input bsp_pkg::out_item_t res_data
);
	import bsp_pkg::*;

	// The buzzer sounds exactly in the sounding phase.
	a_buzzer_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.buzzer_on == (res_data.phase == PHASE_SOUND)))
		else $error("buzzer level disagrees with phase");

	// Any phase other than idle belongs to a running alert.
	a_busy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.phase != PHASE_IDLE) |-> res_data.busy_res)
		else $error("active phase without busy");

	// A dropped enqueue never moves the player, so it cannot start a sound.
	a_drop_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready ##1 res_valid && res_data.dropped) |->
		(res_data.phase == $past(res_data.phase) && res_data.busy_res == $past(res_data.busy_res)))
		else $error("dropped request changed the player state");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
		else $error("result changed while stalled");

endmodule

bind beep_sequence_player_core bsp_checker u_bsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_data  (results.data)
);

>>> tb/beep_sequence_player_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for beep_sequence_player_core: a queue-fed driver, a random
// stall receiver and a monitor that scores every result against a cycle-free player model.
// Depends on bsp_pkg, the bsp_in_if/bsp_out_if interfaces and the core itself.
module beep_sequence_player_core_tb;
	import bsp_pkg::*;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int REPORT_MAX = 10;

	logic                 clk;
	logic                 arst_n;
	logic                 write_en;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     write_data;

	bsp_in_if  items_ch ();
	bsp_out_if results_ch ();

	beep_sequence_player_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items_ch),
		.results    (results_ch),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data)
	);

	// Requests waiting for the driver, and results the player model says are due.
	in_item_t  pending_requests [$];
	out_item_t expected_results [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned fault_count;
	int unsigned idle_cycles;
	int unsigned queued_count;

	// Player model state: beep ring, pointers, phase, counter and registers.
	beep_t       ring [QUEUE_SLOTS];
	int unsigned rd_slot;
	int unsigned wr_slot;
	logic [1:0]  cur_phase;
	logic [15:0] ticks;
	logic [15:0] cur_len;
	logic        cur_fin;
	logic        busy;
	logic [15:0] gap_cfg;
	logic [15:0] pause_cfg;

	// Apply one request to the model and return the result it produces.
	function automatic out_item_t step_player(in_item_t req);
		out_item_t   res;
		int unsigned nxt;
		res = '0;
		if (req.cmd == CMD_ENQUEUE) begin
			// Keep one slot free: a full ring drops the beep and flags it.
			nxt = (wr_slot + 1) % QUEUE_SLOTS;
			if (nxt != rd_slot) begin
				ring[wr_slot] = {req.beep_length, req.beep_final};
				wr_slot = nxt;
			end else begin
				res.dropped = 1'b1;
			end
		end else begin
			// Saturate the tick counter, then advance the player by one tick.
			if (ticks != 16'hFFFF)
				ticks = ticks + 16'd1;
			case (cur_phase)
				PHASE_IDLE: begin
					if (rd_slot != wr_slot) begin
						cur_len = ring[rd_slot].len;
						cur_fin = ring[rd_slot].fin;
						rd_slot = (rd_slot + 1) % QUEUE_SLOTS;
						ticks = '0;
						cur_phase = PHASE_SOUND;
						busy = 1'b1;
					end
				end
				PHASE_SOUND: begin
					if (ticks >= cur_len) begin
						ticks = '0;
						cur_phase = PHASE_GAP;
					end
				end
				PHASE_GAP: begin
					if (ticks >= gap_cfg) begin
						ticks = '0;
						cur_phase = cur_fin ? PHASE_PAUSE : PHASE_IDLE;
					end
				end
				default: begin
					// End of the final pause empties the ring, pending beeps included.
					if (ticks >= pause_cfg) begin
						ticks = '0;
						rd_slot = 0;
						wr_slot = 0;
						cur_phase = PHASE_IDLE;
						busy = 1'b0;
					end
				end
			endcase
		end
		res.buzzer_on = (cur_phase == PHASE_SOUND);
		res.busy_res = busy;
		res.phase = cur_phase;
		return res;
	endfunction

	task automatic push_request(logic cmd, logic [15:0] len, logic fin);
		pending_requests.push_back(in_item_t'({cmd, len, fin}));
		queued_count++;
	endtask

	// Ticks carry random payload so every input bit toggles.
	task automatic push_tick();
		push_request(CMD_TICK, 16'($urandom), 1'($urandom));
	endtask

	// Queue a whole alert, 1 to 4 beeps, then roughly enough ticks to play it out.
	// Now and then cut the ticks short so enqueues land in the middle of an alert.
	task automatic queue_alert();
		int          n;
		int          i;
		int          r;
		int          ticks_needed;
		logic [15:0] len;
		logic        fin;
		n = $urandom_range(1, 4);
		ticks_needed = 0;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 70)
				len = 16'($urandom_range(0, 5));
			else if (r < 95)
				len = 16'($urandom_range(6, 30));
			else
				len = 16'($urandom_range(31, 200));
			if (i == n - 1)
				fin = ($urandom_range(9) != 0);
			else
				fin = ($urandom_range(19) == 0);
			push_request(CMD_ENQUEUE, len, fin);
			ticks_needed += int'(len) + int'(gap_cfg) + 2;
		end
		ticks_needed += int'(pause_cfg) + 2;
		if ($urandom_range(4) == 0)
			ticks_needed = $urandom_range(0, ticks_needed);
		repeat (ticks_needed)
			push_tick();
	endtask

	// Hold until the driver has sent everything and every result has come back.
	task automatic drain();
		while (pending_requests.size() != 0 || items_ch.valid ||
			expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Write one register while the block is idle and mirror it into the model.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		write_en <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		if (idx == CFG_GAP_TICKS)
			gap_cfg = val;
		else if (idx == CFG_FINAL_PAUSE)
			pause_cfg = val;
		@(posedge clk);
		write_en <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: present the next pending request once the previous one is taken,
	// idling at random; valid and data get exactly one update per edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			items_ch.valid <= 1'b0;
		end else if (!items_ch.valid || items_ch.ready) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				items_ch.valid <= 1'b1;
				items_ch.data <= pending_requests.pop_front();
			end else begin
				items_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random.
	always @(posedge clk) begin
		if (!arst_n)
			results_ch.ready <= 1'b0;
		else
			results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: score the result taken at this edge, then predict for the request
	// taken at this edge; also watch for a hang.
	always @(posedge clk) begin
		out_item_t want;
		logic      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (results_ch.valid && results_ch.ready) begin
				moved = 1'b1;
				if (expected_results.size() == 0) begin
					if (fault_count < REPORT_MAX) begin
						$write("result with nothing expected: ");
						$display("buzzer=%0b busy=%0b dropped=%0b phase=%0d",
							results_ch.data.buzzer_on, results_ch.data.busy_res,
							results_ch.data.dropped, results_ch.data.phase);
					end
					fault_count++;
				end else begin
					want = expected_results.pop_front();
					if (results_ch.data.buzzer_on !== want.buzzer_on ||
						results_ch.data.busy_res !== want.busy_res ||
						results_ch.data.dropped !== want.dropped ||
						results_ch.data.phase !== want.phase) begin
						if (fault_count < REPORT_MAX) begin
							$write("mismatch: expected buzzer=%0b busy=%0b dropped=%0b phase=%0d, ",
								want.buzzer_on, want.busy_res, want.dropped, want.phase);
							$display("got buzzer=%0b busy=%0b dropped=%0b phase=%0d",
								results_ch.data.buzzer_on, results_ch.data.busy_res,
								results_ch.data.dropped, results_ch.data.phase);
						end
						fault_count++;
					end
				end
			end
			if (items_ch.valid && items_ch.ready) begin
				moved = 1'b1;
				expected_results.push_back(step_player(items_ch.data));
			end
			if (moved)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int p;
		int i;
		bit paused;
		// Drive every input to a known value from time zero.
		arst_n = 1'b0;
		write_en = 1'b0;
		reg_index = CFG_GAP_TICKS;
		write_data = '0;
		items_ch.valid = 1'b0;
		items_ch.data = '0;
		results_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fault_count = 0;
		idle_cycles = 0;
		queued_count = 0;
		paused = 0;
		// Model reset state.
		for (i = 0; i < QUEUE_SLOTS; i++)
			ring[i] = '0;
		rd_slot = 0;
		wr_slot = 0;
		cur_phase = PHASE_IDLE;
		ticks = '0;
		cur_len = '0;
		cur_fin = 1'b0;
		busy = 1'b0;
		gap_cfg = GAP_TICKS_RESET;
		pause_cfg = FINAL_PAUSE_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: short gap and pause so a full alert fits in a few ticks.
		write_reg(CFG_GAP_TICKS, 16'd1);
		write_reg(CFG_FINAL_PAUSE, 16'd2);
		@(negedge clk);
		// Tick on an empty idle player.
		push_request(CMD_TICK, 16'hFFFF, 1'b1);
		// Fill the ring: zero length first, then a short beep, a final beep and one more behind it.
		push_request(CMD_ENQUEUE, 16'd0, 1'b0);
		push_request(CMD_ENQUEUE, 16'd2, 1'b0);
		push_request(CMD_ENQUEUE, 16'd1, 1'b1);
		push_request(CMD_ENQUEUE, 16'd3, 1'b0);
		// Ring full: drop the widest beep.
		push_request(CMD_ENQUEUE, 16'hFFFF, 1'b1);
		// Play through both beeps and the final beep into its pause.
		repeat (10) push_request(CMD_TICK, 16'h0000, 1'b0);
		// Enqueue during the final pause, then let the pause end and discard it.
		push_request(CMD_ENQUEUE, 16'd5, 1'b0);
		repeat (3) push_tick();
		drain();

		// An index without a register must leave the settings untouched.
		write_reg(CFG_UNUSED, 16'($urandom));

		// Random phases over every idling mode; zero gap and zero pause in some.
		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 57;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 57;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			write_reg(CFG_GAP_TICKS, (p == 1 || p == 5) ? 16'd0 : 16'($urandom_range(0, 6)));
			write_reg(CFG_FINAL_PAUSE, (p == 1) ? 16'd0 : 16'($urandom_range(0, 12)));
			@(negedge clk);
			queued_count = 0;
			while (queued_count < 250) begin
				// Once, stop feeding halfway until every result is back.
				if (p == 2 && !paused && queued_count >= 125) begin
					drain();
					paused = 1;
				end
				if ($urandom_range(9) < 8) begin
					queue_alert();
				end else begin
					// Noise: stray enqueues and ticks.
					repeat ($urandom_range(1, 6)) begin
						if ($urandom_range(2) == 0)
							push_request(CMD_ENQUEUE, 16'($urandom_range(0, 8)),
								1'($urandom_range(1)));
						else
							push_tick();
					end
				end
			end
			drain();
		end

		// Flush the player to idle with an empty ring before the widest settings.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(CFG_GAP_TICKS, 16'd0);
		write_reg(CFG_FINAL_PAUSE, 16'd0);
		@(negedge clk);
		while (cur_phase != PHASE_IDLE || rd_slot != wr_slot) begin
			repeat (300) push_tick();
			drain();
		end

		// Widest beep, gap and pause; start the beep and sound it for a while.
		write_reg(CFG_GAP_TICKS, 16'hFFFF);
		write_reg(CFG_FINAL_PAUSE, 16'hFFFF);
		@(negedge clk);
		push_request(CMD_ENQUEUE, 16'hFFFF, 1'b1);
		repeat (40) push_tick();
		drain();

		repeat (8) @(posedge clk);
		if (fault_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> beep_sequence_player_core.f
src/bsp_pkg.sv
src/bsp_if.sv
src/bsp_front.sv
src/bsp_back.sv
src/beep_sequence_player_core.sv
src/bsp_checker.sv
tb/beep_sequence_player_core_tb.sv
